>>> rtl/line_pixel_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// line pixel rasterizer assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define LPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// shared types and codes of the line pixel rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpr_pkg;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_NEXT  = 1'b1;

    typedef struct packed {
        logic load;
        logic walk;
        logic emit;
    } lpr_cmd_t;

    typedef struct packed {
        logic load_walk;
        logic walk_last;
        logic line_active;
    } lpr_sts_t;

endpackage

>>> rtl/lpr_datapath.sv
// ----------------------------------------------------------------------------
// lpr_datapath
// endpoint setup, error walk, step buffer and pixel output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpr_datapath
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int MAX_LEN    = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lpr_cmd_t                     cmd,
    output lpr_sts_t                     sts,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         last
);

    localparam int SW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 2;
    localparam int KW = SW + 1;
    localparam int AW = $clog2(MAX_LEN);

    logic                         line_active_reg, line_active_next;
    logic                         major_x_reg, major_x_next;
    logic                         rev_reg, rev_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [EW-1:0]         err_reg, err_next;
    logic        [SW-1:0]         maj_reg, maj_next;
    logic        [SW-1:0]         min_reg, min_next;
    logic signed [1:0]            dir_reg, dir_next;
    logic        [SW-1:0]         pl_reg, pl_next;
    logic        [SW-1:0]         walk_cnt_reg, walk_cnt_next;
    logic                         rd_ok_reg, rd_ok_next;
    logic                         rd_data_reg;
    logic signed [COORD_BITS-1:0] pixel_x_reg, pixel_y_reg;
    logic                         last_reg;

    logic step_mem [MAX_LEN];

    // setup of a new line
    logic signed [SW-1:0]         dx, dy;
    logic        [SW-1:0]         adx, ady;
    logic                         ld_major_x, ld_rev;
    logic signed [COORD_BITS-1:0] ld_sx, ld_sy, ld_ex, ld_ey;
    logic signed [1:0]            ld_dir;
    logic        [SW-1:0]         ld_maj, ld_min;

    // walk step
    logic signed [EW:0]           err2, maj_cmp;
    logic                         step;
    logic signed [EW-1:0]         err_step;
    logic signed [COORD_BITS-1:0] dir_ext;
    logic signed [COORD_BITS-1:0] fwd_x, fwd_y, rev_x, rev_y;
    logic                         rd_bit;

    logic                         wr_en;
    logic        [AW-1:0]         wr_addr, rd_addr;
    logic signed [KW-1:0]         k_next;

    always_comb begin
        dx  = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
        dy  = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
        adx = dx[SW-1] ? SW'(-dx) : SW'(dx);
        ady = dy[SW-1] ? SW'(-dy) : SW'(dy);
        ld_major_x = adx > ady;
        ld_rev     = ld_major_x ? (x_start > x_end) : (y_start > y_end);
        ld_sx = ld_rev ? x_end   : x_start;
        ld_sy = ld_rev ? y_end   : y_start;
        ld_ex = ld_rev ? x_start : x_end;
        ld_ey = ld_rev ? y_start : y_end;
        if (ld_major_x) begin
            ld_dir = (ld_ey > ld_sy) ? 2'sb01 : ((ld_ey < ld_sy) ? 2'sb11 : 2'sb00);
        end else begin
            ld_dir = (ld_ex > ld_sx) ? 2'sb01 : ((ld_ex < ld_sx) ? 2'sb11 : 2'sb00);
        end
        ld_maj = ld_major_x ? adx : ady;
        ld_min = ld_major_x ? ady : adx;
    end

    always_comb begin
        err2     = {err_reg, 1'b0};
        maj_cmp  = $signed({2'b00, maj_reg});
        step     = err2 >= maj_cmp;
        err_step = err_reg - (step ? $signed({1'b0, maj_reg}) : EW'(0))
                   + $signed({1'b0, min_reg});
        dir_ext  = {{(COORD_BITS-2){dir_reg[1]}}, dir_reg};
        rd_bit   = rd_data_reg & rd_ok_reg;
        if (major_x_reg) begin
            fwd_x = cur_x_reg + COORD_BITS'(1);
            fwd_y = cur_y_reg + (step ? dir_ext : COORD_BITS'(0));
            rev_x = cur_x_reg - COORD_BITS'(1);
            rev_y = cur_y_reg - (rd_bit ? dir_ext : COORD_BITS'(0));
        end else begin
            fwd_y = cur_y_reg + COORD_BITS'(1);
            fwd_x = cur_x_reg + (step ? dir_ext : COORD_BITS'(0));
            rev_y = cur_y_reg - COORD_BITS'(1);
            rev_x = cur_x_reg - (rd_bit ? dir_ext : COORD_BITS'(0));
        end
    end

    always_comb begin
        line_active_next = line_active_reg;
        major_x_next     = major_x_reg;
        rev_next         = rev_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        err_next         = err_reg;
        maj_next         = maj_reg;
        min_next         = min_reg;
        dir_next         = dir_reg;
        pl_next          = pl_reg;
        walk_cnt_next    = walk_cnt_reg;
        if (cmd.load) begin
            line_active_next = 1'b1;
            major_x_next     = ld_major_x;
            rev_next         = ld_rev;
            cur_x_next       = ld_sx;
            cur_y_next       = ld_sy;
            err_next         = $signed({1'b0, ld_min});
            maj_next         = ld_maj;
            min_next         = ld_min;
            dir_next         = ld_dir;
            pl_next          = ld_maj + SW'(1);
            walk_cnt_next    = '0;
        end else if (cmd.walk) begin
            cur_x_next    = fwd_x;
            cur_y_next    = fwd_y;
            err_next      = err_step;
            walk_cnt_next = walk_cnt_reg + SW'(1);
        end else if (cmd.emit) begin
            pl_next = pl_reg - SW'(1);
            if (pl_reg == SW'(1)) begin
                line_active_next = 1'b0;
            end else if (rev_reg) begin
                cur_x_next = rev_x;
                cur_y_next = rev_y;
            end else begin
                cur_x_next = fwd_x;
                cur_y_next = fwd_y;
                err_next   = err_step;
            end
        end
    end

    // prefetch the step bit for the next reverse move
    always_comb begin
        k_next     = $signed({1'b0, pl_next}) - KW'(2);
        rd_ok_next = (k_next >= 0) && (int'(k_next) < MAX_LEN);
        rd_addr    = AW'($unsigned(k_next));
        wr_en      = cmd.walk && (int'(walk_cnt_reg) < MAX_LEN);
        wr_addr    = AW'(walk_cnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            major_x_reg     <= 1'b0;
            rev_reg         <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            err_reg         <= '0;
            maj_reg         <= '0;
            min_reg         <= '0;
            dir_reg         <= '0;
            pl_reg          <= '0;
            walk_cnt_reg    <= '0;
            rd_ok_reg       <= 1'b0;
        end else begin
            line_active_reg <= line_active_next;
            major_x_reg     <= major_x_next;
            rev_reg         <= rev_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            err_reg         <= err_next;
            maj_reg         <= maj_next;
            min_reg         <= min_next;
            dir_reg         <= dir_next;
            pl_reg          <= pl_next;
            walk_cnt_reg    <= walk_cnt_next;
            rd_ok_reg       <= rd_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            step_mem[wr_addr] <= step;
        end
        rd_data_reg <= step_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            pixel_x_reg <= cur_x_reg;
            pixel_y_reg <= cur_y_reg;
            last_reg    <= (pl_reg == SW'(1));
        end
    end

    assign sts.load_walk   = ld_rev && (ld_maj != '0);
    assign sts.walk_last   = (walk_cnt_reg == maj_reg - SW'(1));
    assign sts.line_active = line_active_reg;

    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign last    = last_reg;

endmodule

>>> rtl/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// lpr_ctrl
// handshake control and sequencing of the step buffer walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_kind,
    output logic     m_valid,
    input  logic     m_ready,
    output lpr_cmd_t cmd,
    input  lpr_sts_t sts
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_SETTLE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    always_comb begin
        s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
        accept   = s_valid && s_ready;
        cmd.load = accept && (s_kind == KIND_START);
        cmd.emit = accept && (s_kind == KIND_NEXT) && sts.line_active;
        cmd.walk = (state_reg == ST_WALK);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load && sts.load_walk) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (sts.walk_last) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/line_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// next-pixel transaction: result in the output register in the cycle after
//   acceptance, one pixel per cycle while m_ready stays high
// start transaction: after acceptance, a line walked in reverse holds s_ready
//   low through the WALK state, writing step bits, and SETTLE, reading back
// reset: synchronous active-low aresetn clears line and handshake state,
//   not the step buffer or the pixel output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_pixel_rasterizer_assert.svh"

module line_pixel_rasterizer
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int MAX_LEN    = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic signed [COORD_BITS-1:0] s_x_start,
    input  logic signed [COORD_BITS-1:0] s_y_start,
    input  logic signed [COORD_BITS-1:0] s_x_end,
    input  logic signed [COORD_BITS-1:0] s_y_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_pixel_x,
    output logic signed [COORD_BITS-1:0] m_pixel_y,
    output logic                         m_last
);

    lpr_cmd_t cmd;
    lpr_sts_t sts;

    lpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    lpr_datapath #(
        .COORD_BITS (COORD_BITS),
        .MAX_LEN    (MAX_LEN)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .x_start (s_x_start),
        .y_start (s_y_start),
        .x_end   (s_x_end),
        .y_end   (s_y_end),
        .pixel_x (m_pixel_x),
        .pixel_y (m_pixel_y),
        .last    (m_last)
    );

    `LPR_ASSERT_IMP(a_walk_blocks_input, cmd.walk, !s_ready, "input taken during walk")
    `LPR_ASSERT_NXT(a_emit_shows_valid, cmd.emit, m_valid, "emitted pixel not presented")
    `LPR_ASSERT_NXT(a_start_activates, cmd.load, sts.line_active, "start did not activate line")
    `LPR_ASSERT_IMP(a_no_emit_idle, !sts.line_active, !cmd.emit, "pixel emitted with no line")

endmodule

>>> tb/sv/line_pixel_rasterizer_test.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_test
// self-checking bench for the line rasterizer: a queue of start and next
// transactions feeds a clocked driver, a local bresenham walker predicts each
// pixel at acceptance, and a clocked monitor compares every pixel in order.
// both sides idle at random, with quiet stretches and at least one full drain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_rasterizer_test;
    import lpr_pkg::*;

    localparam int CW      = 12;
    localparam int BUF_LEN = 4096;
    localparam int LO      = -2048;
    localparam int HI      = 2047;

    typedef struct {
        logic                 kind;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] xe;
        logic signed [CW-1:0] ye;
        bit                   drain_first;
    } line_cmd_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } pixel_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_kind    = KIND_NEXT;
    logic signed [CW-1:0] s_x_start = '0;
    logic signed [CW-1:0] s_y_start = '0;
    logic signed [CW-1:0] s_x_end   = '0;
    logic signed [CW-1:0] s_y_end   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic signed [CW-1:0] m_pixel_x;
    logic signed [CW-1:0] m_pixel_y;
    logic                 m_last;

    line_cmd_t line_cmds[$];
    pixel_t    pixels_due[$];
    line_cmd_t on_bus;
    int        accepted_cnt = 0;
    int        cmd_total    = 0;
    int        fail_cnt     = 0;
    int        send_gap     = 0;
    int        hold_cnt     = 0;
    int        quiet_cnt    = 0;
    bit        quiet        = 1'b0;

    // walker state
    bit                   line_on;
    bit                   major_x;
    bit                   walk_back;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    int                   err_acc;
    int                   span_major;
    int                   span_minor;
    int                   dir_minor;
    int                   remaining;
    bit                   minor_steps[BUF_LEN];

    line_pixel_rasterizer #(
        .COORD_BITS(CW),
        .MAX_LEN   (BUF_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_kind   (s_kind),
        .s_x_start(s_x_start),
        .s_y_start(s_y_start),
        .s_x_end  (s_x_end),
        .s_y_end  (s_y_end),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_pixel_x(m_pixel_x),
        .m_pixel_y(m_pixel_y),
        .m_last   (m_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int mag(input int d);
        return (d < 0) ? -d : d;
    endfunction

    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void shift_pixel(input int dmaj, input int dmin);
        if (major_x) begin
            px = CW'(int'(px) + dmaj);
            py = CW'(int'(py) + dmin);
        end else begin
            py = CW'(int'(py) + dmaj);
            px = CW'(int'(px) + dmin);
        end
    endfunction

    function automatic bit advance_forward();
        bit stp;
        stp = (2 * err_acc >= span_major);
        if (stp) err_acc -= span_major;
        err_acc += span_minor;
        shift_pixel(1, stp ? dir_minor : 0);
        return stp;
    endfunction

    function automatic void load_line(input line_cmd_t c);
        int xs, ys, xe, ye, dx, dy, t, d;
        xs = int'(c.xs);
        ys = int'(c.ys);
        xe = int'(c.xe);
        ye = int'(c.ye);
        dx = mag(xe - xs);
        dy = mag(ye - ys);
        major_x   = dx > dy;
        walk_back = major_x ? (xs > xe) : (ys > ye);
        if (walk_back) begin
            t = xs; xs = xe; xe = t;
            t = ys; ys = ye; ye = t;
        end
        d = major_x ? (ye - ys) : (xe - xs);
        dir_minor  = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
        span_major = major_x ? dx : dy;
        span_minor = major_x ? dy : dx;
        px         = CW'(xs);
        py         = CW'(ys);
        err_acc    = span_minor;
        remaining  = span_major + 1;
        line_on    = 1'b1;
        if (walk_back) begin
            for (int i = 0; i < span_major; i++) begin
                minor_steps[i] = advance_forward();
            end
        end
    endfunction

    function automatic void emit_pixel();
        pixel_t p;
        int     k;
        p.x = px;
        p.y = py;
        remaining -= 1;
        if (remaining <= 0) begin
            remaining = 0;
            line_on   = 1'b0;
            p.last    = 1'b1;
        end else begin
            p.last = 1'b0;
            if (walk_back) begin
                k = remaining - 1;
                shift_pixel(-1, minor_steps[k] ? -dir_minor : 0);
            end else begin
                void'(advance_forward());
            end
        end
        pixels_due.push_back(p);
    endfunction

    function automatic void apply_cmd(input line_cmd_t c);
        if (c.kind == KIND_START) load_line(c);
        else if (line_on) emit_pixel();
    endfunction

    task automatic add_start(input int xs, input int ys, input int xe, input int ye,
                             input bit drain);
        line_cmd_t c;
        c.kind        = KIND_START;
        c.xs          = CW'(xs);
        c.ys          = CW'(ys);
        c.xe          = CW'(xe);
        c.ye          = CW'(ye);
        c.drain_first = drain;
        line_cmds.push_back(c);
    endtask

    task automatic add_next(input int n);
        line_cmd_t c;
        for (int i = 0; i < n; i++) begin
            c.kind        = KIND_NEXT;
            c.xs          = CW'($urandom);
            c.ys          = CW'($urandom);
            c.xe          = CW'($urandom);
            c.ye          = CW'($urandom);
            c.drain_first = 1'b0;
            line_cmds.push_back(c);
        end
    endtask

    function automatic int any_coord();
        return int'($urandom_range(0, 4095)) + LO;
    endfunction

    function automatic int near_edge();
        return $urandom_range(0, 1) ? HI - int'($urandom_range(0, 6))
                                    : LO + int'($urandom_range(0, 6));
    endfunction

    function automatic int jitter(input int b);
        int v;
        v = b + int'($urandom_range(0, 40)) - 20;
        return (v < LO) ? LO : ((v > HI) ? HI : v);
    endfunction

    // driver
    always @(posedge aclk) begin : drive_proc
        line_cmd_t nxt;
        logic      v_next;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            v_next = s_valid;
            if (s_valid && s_ready) begin
                apply_cmd(on_bus);
                accepted_cnt <= accepted_cnt + 1;
                v_next = 1'b0;
            end
            if (!v_next) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                end else if (line_cmds.size() != 0 &&
                             !(line_cmds[0].drain_first && pixels_due.size() != 0)) begin
                    nxt = line_cmds.pop_front();
                    on_bus    <= nxt;
                    s_kind    <= nxt.kind;
                    s_x_start <= nxt.xs;
                    s_y_start <= nxt.ys;
                    s_x_end   <= nxt.xe;
                    s_y_end   <= nxt.ye;
                    send_gap  <= idle_len();
                    v_next = 1'b1;
                end
            end
            s_valid <= v_next;
        end
    end

    // monitor
    always @(posedge aclk) begin : watch_proc
        pixel_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    $display("%0t: unexpected pixel x %0d y %0d last %0b",
                             $time, m_pixel_x, m_pixel_y, m_last);
                    fail_cnt++;
                end else begin
                    want = pixels_due.pop_front();
                    if (m_pixel_x !== want.x) begin
                        $display("%0t: pixel_x expected %0d actual %0d",
                                 $time, want.x, m_pixel_x);
                        fail_cnt++;
                    end
                    if (m_pixel_y !== want.y) begin
                        $display("%0t: pixel_y expected %0d actual %0d",
                                 $time, want.y, m_pixel_y);
                        fail_cnt++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, m_last);
                        fail_cnt++;
                    end
                end
            end
            if (hold_cnt != 0) begin
                m_ready  <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end else begin
                m_ready  <= 1'b1;
                hold_cnt <= idle_len();
            end
        end
    end

    // stretches with no idling on either side
    always @(posedge aclk) begin
        if (quiet_cnt == 0) begin
            quiet     <= ($urandom_range(0, 3) == 0);
            quiet_cnt <= $urandom_range(50, 300);
        end else begin
            quiet_cnt <= quiet_cnt - 1;
        end
    end

    initial begin : run_proc
        int xs, ys, xe, ye, len, n, made, pick, shape;
        bit first;

        // directed: idle next, single point, full-range lines, replacement
        add_next(1);
        add_start(0, 0, 0, 0, 1'b0);
        add_next(2);
        add_start(LO, HI, HI, LO, 1'b0);
        add_next(2);
        add_start(HI, LO, LO, HI, 1'b0);
        add_next(2);
        add_start(3, 0, -1, 1, 1'b0);
        add_next(5);
        add_start(HI - 2, HI - 1, HI, HI, 1'b0);
        add_next(4);
        add_start(LO + 2, LO + 1, LO, LO, 1'b0);
        add_next(3);

        made  = 0;
        first = 1'b1;
        while (made < 1000) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                xs = any_coord();
                ys = any_coord();
                xe = any_coord();
                ye = any_coord();
            end else if (pick < 20) begin
                xs = near_edge();
                ys = near_edge();
                xe = jitter(xs);
                ye = jitter(ys);
            end else begin
                xs = any_coord();
                ys = any_coord();
                xe = jitter(xs);
                ye = jitter(ys);
            end
            add_start(xs, ys, xe, ye, first || ($urandom_range(0, 99) == 0));
            first = 1'b0;
            len = ((mag(xe - xs) > mag(ye - ys)) ? mag(xe - xs) : mag(ye - ys)) + 1;
            n = (len > 40) ? 40 : len;
            shape = $urandom_range(0, 99);
            if (shape < 15) n = $urandom_range(0, n - 1);
            add_next(n);
            made += 1 + n;
            if (shape >= 85) add_next($urandom_range(1, 2));
        end
        cmd_total = line_cmds.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt != cmd_total || pixels_due.size() != 0) @(posedge aclk);
        repeat (BUF_LEN + 100) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/lpr_pkg.sv
rtl/lpr_datapath.sv
rtl/lpr_ctrl.sv
rtl/line_pixel_rasterizer.sv
tb/sv/line_pixel_rasterizer_test.sv
